// ===== hw/rtl/hsvgrb_pkg.sv =====
// shared widths, constants and stage payload types of the hsv to grb converter
`default_nettype none

package hsvgrb_pkg;

    localparam int HUE_W  = 9;
    localparam int CH_W   = 8;
    localparam int GRB_W  = 24;
    localparam int SECT_W = 4;
    localparam int PROD_W = 2 * CH_W;

    localparam logic [HUE_W-1:0] HUE_MAX      = 9'd360;
    localparam int               SECTOR_WIDTH = 43;
    localparam int               REM_SCALE    = 6;
    localparam logic [CH_W-1:0]  FULL_LEVEL   = 8'd255;
    localparam logic [CH_W-1:0]  REM_MAX      = 8'd252;

    // hue / 43 as (hue * 382) >> 14, exact for hue 0..360
    localparam int RECIP       = 382;
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_W     = HUE_W + 9;

    localparam logic [SECT_W-1:0] SECT_RED_YEL  = 4'd0;
    localparam logic [SECT_W-1:0] SECT_YEL_GRN  = 4'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN  = 4'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU  = 4'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG  = 4'd4;
    localparam logic [SECT_W-1:0] SECT_LAST_MAX = 4'd8;

    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic [CH_W-1:0]   rem;
        logic [CH_W-1:0]   sat;
        logic [CH_W-1:0]   bri;
        logic [CH_W-1:0]   p;
    } sec_t;

    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic [CH_W-1:0]   bri;
        logic [CH_W-1:0]   p;
        logic [CH_W-1:0]   q;
        logic [CH_W-1:0]   t;
    } terms_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsv_pixel_if.sv =====
// input channel carrying one hsv pixel item
`default_nettype none

interface hsv_pixel_if
    import hsvgrb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/grb_word_if.sv =====
// output channel carrying one packed grb color item
`default_nettype none

interface grb_word_if
    import hsvgrb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [GRB_W-1:0] grb_word;

    modport source (output valid, output grb_word, input ready);
    modport sink   (input valid, input grb_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hsvgrb_sector.sv =====
// stages one and two: hue clamp, sector, scaled remainder and the p term
`default_nettype none

module hsvgrb_sector
    import hsvgrb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [HUE_W-1:0] hue,
    input  wire logic [CH_W-1:0]  sat,
    input  wire logic [CH_W-1:0]  bri,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sec_t                  out_data
);

    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               s1_ready;
    logic               s2_ready;

    logic [HUE_W-1:0]   hue_clamped;
    logic [RECIP_W-1:0] recip_prod;

    logic [HUE_W-1:0]   h1_reg;
    logic [SECT_W-1:0]  sec1_reg;
    logic [SECT_W-1:0]  sec1_next;
    logic [CH_W-1:0]    sat1_reg;
    logic [CH_W-1:0]    bri1_reg;

    logic [HUE_W-1:0]   sect_base;
    logic [5:0]         sect_offset;
    logic [PROD_W-1:0]  p_prod;
    sec_t               s2_next;
    sec_t               s2_reg;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_ready = !s2_valid_reg || out_ready;
    assign in_ready = s1_ready;

    assign hue_clamped = (hue > HUE_MAX) ? HUE_MAX : hue;
    assign recip_prod  = RECIP_W'(hue_clamped) * RECIP_W'(RECIP);
    assign sec1_next   = recip_prod[RECIP_SHIFT +: SECT_W];

    // remainder within the sector, scaled by six
    assign sect_base   = HUE_W'(sec1_reg) * HUE_W'(SECTOR_WIDTH);
    assign sect_offset = 6'(h1_reg - sect_base);
    assign p_prod      = PROD_W'(bri1_reg) * PROD_W'(FULL_LEVEL - sat1_reg);

    always_comb
    begin
        s2_next.sector = sec1_reg;
        s2_next.rem    = CH_W'(CH_W'(sect_offset) * CH_W'(REM_SCALE));
        s2_next.sat    = sat1_reg;
        s2_next.bri    = bri1_reg;
        s2_next.p      = p_prod[PROD_W-1 -: CH_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            h1_reg   <= hue_clamped;
            sec1_reg <= sec1_next;
            sat1_reg <= sat;
            bri1_reg <= bri;
        end
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_reg.rem <= REM_MAX))
        else $error("scaled remainder out of range");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (sec1_reg <= SECT_LAST_MAX && h1_reg >= sect_base))
        else $error("sector does not match clamped hue");

    a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_reg.p <= s2_reg.bri))
        else $error("p term above brightness");

endmodule

`default_nettype wire

// ===== hw/rtl/hsvgrb_terms.sv =====
// stages three and four: saturation products, then the q and t terms
`default_nettype none

module hsvgrb_terms
    import hsvgrb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sec_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output terms_t    out_data
);

    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic [CH_W-1:0]   bri;
        logic [CH_W-1:0]   p;
        logic [CH_W-1:0]   sq;
        logic [CH_W-1:0]   st;
    } scaled_t;

    logic              s3_valid_reg;
    logic              s4_valid_reg;
    logic              s3_ready;
    logic              s4_ready;

    logic [PROD_W-1:0] sq_prod;
    logic [PROD_W-1:0] st_prod;
    scaled_t           s3_next;
    scaled_t           s3_reg;

    logic [PROD_W-1:0] q_prod;
    logic [PROD_W-1:0] t_prod;
    terms_t            s4_next;
    terms_t            s4_reg;

    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s4_ready = !s4_valid_reg || out_ready;
    assign in_ready = s3_ready;

    assign sq_prod = PROD_W'(in_data.sat) * PROD_W'(in_data.rem);
    assign st_prod = PROD_W'(in_data.sat) * PROD_W'(FULL_LEVEL - in_data.rem);

    always_comb
    begin
        s3_next.sector = in_data.sector;
        s3_next.bri    = in_data.bri;
        s3_next.p      = in_data.p;
        s3_next.sq     = sq_prod[PROD_W-1 -: CH_W];
        s3_next.st     = st_prod[PROD_W-1 -: CH_W];
    end

    assign q_prod = PROD_W'(s3_reg.bri) * PROD_W'(FULL_LEVEL - s3_reg.sq);
    assign t_prod = PROD_W'(s3_reg.bri) * PROD_W'(FULL_LEVEL - s3_reg.st);

    always_comb
    begin
        s4_next.sector = s3_reg.sector;
        s4_next.bri    = s3_reg.bri;
        s4_next.p      = s3_reg.p;
        s4_next.q      = q_prod[PROD_W-1 -: CH_W];
        s4_next.t      = t_prod[PROD_W-1 -: CH_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
                s3_valid_reg <= in_valid;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && in_valid)
            s3_reg <= s3_next;
        if (s4_ready && s3_valid_reg)
            s4_reg <= s4_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_reg;

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_reg.q <= s4_reg.bri))
        else $error("q term above brightness");

    a_t_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_reg.t <= s4_reg.bri))
        else $error("t term above brightness");

    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && !out_ready) |=> s4_valid_reg)
        else $error("stalled item dropped from stage four");

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_to_grb_color_converter.sv =====
// top level of the hsv to grb color converter: pipeline and channel select
`default_nettype none

// Converts one hue/saturation/brightness item into a packed grb word
// (green 23-16, red 15-8, blue 7-0). Five register stages: clamp and sector,
// remainder and p, saturation products, q and t, channel select into the
// output register. One item is accepted every clock unless a stall on the
// output has backed up to the input. Each stage holds its item while the
// next is full, so a stall on the output backs up stage by stage without
// loss. Hues above 360 are treated as 360; sectors five and up share the
// last channel selection.
module hsv_to_grb_color_converter
    import hsvgrb_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    hsv_pixel_if.sink  pixel,
    grb_word_if.source color
);

    logic              sec_valid;
    logic              sec_ready;
    sec_t              sec_data;
    logic              terms_valid;
    logic              terms_ready;
    terms_t            terms_data;

    logic              out_valid_reg;
    logic [GRB_W-1:0]  grb_reg;
    logic [GRB_W-1:0]  grb_next;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;

    hsvgrb_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .hue       (pixel.hue),
        .sat       (pixel.saturation),
        .bri       (pixel.brightness),
        .out_valid (sec_valid),
        .out_ready (sec_ready),
        .out_data  (sec_data)
    );

    hsvgrb_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sec_valid),
        .in_ready  (sec_ready),
        .in_data   (sec_data),
        .out_valid (terms_valid),
        .out_ready (terms_ready),
        .out_data  (terms_data)
    );

    assign terms_ready = !out_valid_reg || color.ready;

    always_comb
    begin
        unique case (terms_data.sector)
            SECT_RED_YEL:
            begin
                red   = terms_data.bri;
                green = terms_data.t;
                blue  = terms_data.p;
            end
            SECT_YEL_GRN:
            begin
                red   = terms_data.q;
                green = terms_data.bri;
                blue  = terms_data.p;
            end
            SECT_GRN_CYN:
            begin
                red   = terms_data.p;
                green = terms_data.bri;
                blue  = terms_data.t;
            end
            SECT_CYN_BLU:
            begin
                red   = terms_data.p;
                green = terms_data.q;
                blue  = terms_data.bri;
            end
            SECT_BLU_MAG:
            begin
                red   = terms_data.t;
                green = terms_data.p;
                blue  = terms_data.bri;
            end
            default:
            begin
                // magenta back to red, and every higher sector
                red   = terms_data.bri;
                green = terms_data.p;
                blue  = terms_data.q;
            end
        endcase
        grb_next = {green, red, blue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (terms_ready)
            out_valid_reg <= terms_valid;
    end

    always_ff @(posedge clk)
    begin
        if (terms_ready && terms_valid)
            grb_reg <= grb_next;
    end

    assign color.valid    = out_valid_reg;
    assign color.grb_word = grb_reg;

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> pixel.ready)
        else $error("input stalled while output stage is empty");

    a_terms_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (terms_valid && terms_ready) |=> out_valid_reg)
        else $error("item lost between stage four and output");

    a_terms_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (terms_valid && !terms_ready) |=> (terms_valid && $stable(terms_data)))
        else $error("stage four changed while stalled");

endmodule

`default_nettype wire

// ===== sim/hsvgrb_checker.sv =====
// checker: watches both channels, predicts each grb word and compares it
`default_nettype none

module hsvgrb_checker
    import hsvgrb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    hsv_pixel_if     pixel,
    grb_word_if      color,
    output int       failures,
    output int       pending
);

    logic [GRB_W-1:0] expected_words[$];

    // upper byte of an 8 x 8 product
    function automatic logic [CH_W-1:0] scale_byte(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] b);
        logic [PROD_W-1:0] prod;
        prod = a * b;
        return prod[PROD_W-1:CH_W];
    endfunction

    function automatic logic [GRB_W-1:0] grb_of_hsv(input logic [HUE_W-1:0] hue_in,
                                                    input logic [CH_W-1:0]  sat,
                                                    input logic [CH_W-1:0]  bri);
        logic [HUE_W-1:0]  h;
        logic [SECT_W-1:0] sector;
        logic [CH_W-1:0]   rem;
        logic [CH_W-1:0]   p;
        logic [CH_W-1:0]   q;
        logic [CH_W-1:0]   t;
        logic [CH_W-1:0]   r;
        logic [CH_W-1:0]   g;
        logic [CH_W-1:0]   b;
        h      = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
        sector = SECT_W'(h / SECTOR_WIDTH);
        rem    = CH_W'((h - sector * SECTOR_WIDTH) * REM_SCALE);
        p = scale_byte(bri, FULL_LEVEL - sat);
        q = scale_byte(bri, FULL_LEVEL - scale_byte(sat, rem));
        t = scale_byte(bri, FULL_LEVEL - scale_byte(sat, FULL_LEVEL - rem));
        case (sector)
            SECT_RED_YEL:
            begin
                r = bri; g = t;   b = p;
            end
            SECT_YEL_GRN:
            begin
                r = q;   g = bri; b = p;
            end
            SECT_GRN_CYN:
            begin
                r = p;   g = bri; b = t;
            end
            SECT_CYN_BLU:
            begin
                r = p;   g = q;   b = bri;
            end
            SECT_BLU_MAG:
            begin
                r = t;   g = p;   b = bri;
            end
            // sectors five and up share one selection
            default:
            begin
                r = bri; g = p;   b = q;
            end
        endcase
        return {g, r, b};
    endfunction

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    always @(posedge clk)
    begin : watch
        logic [GRB_W-1:0] want;
        if (rst_n)
        begin
            // results first: a word never comes from the item accepted at the same edge
            if (color.valid && color.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: grb_word expected none, got %06h", $time,
                             color.grb_word);
                    failures++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (color.grb_word !== want)
                    begin
                        $display("%0t: grb_word expected %06h, got %06h", $time,
                                 want, color.grb_word);
                        failures++;
                    end
                end
            end
            if (pixel.valid && pixel.ready)
                expected_words.push_back(grb_of_hsv(pixel.hue, pixel.saturation,
                                                    pixel.brightness));
            pending = expected_words.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_hsv_to_grb_color_converter.sv =====
// testbench top: clock, reset, pixel stimulus, output stalls and verdict
`default_nettype none

module tb_hsv_to_grb_color_converter;
    import hsvgrb_pkg::*;

    localparam int          RANDOM_ITEMS = 1130;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycle_count = 0;
    int          check_failures;
    int          results_due;
    bit          calm = 1'b0;
    int unsigned stall_left = 0;

    hsv_pixel_if pixel();
    grb_word_if  color();

    hsv_to_grb_color_converter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .color (color)
    );

    hsvgrb_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .color    (color),
        .failures (check_failures),
        .pending  (results_due)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short idle runs, a few long ones, none while calm
    function automatic int unsigned idle_length();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            color.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            color.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            color.ready <= 1'b0;
            stall_left = idle_length();
        end
        else
            color.ready <= 1'b1;
    end

    task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [CH_W-1:0] s,
                              input logic [CH_W-1:0] v);
        int unsigned gap;
        gap = idle_length();
        repeat (gap)
        begin
            @(negedge clk);
            pixel.valid <= 1'b0;
        end
        @(negedge clk);
        pixel.valid      <= 1'b1;
        pixel.hue        <= h;
        pixel.saturation <= s;
        pixel.brightness <= v;
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
    endtask

    task automatic wait_results_done();
        while (results_due != 0)
            @(negedge clk);
    endtask

    function automatic logic [CH_W-1:0] random_level();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return FULL_LEVEL;
        return CH_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [HUE_W-1:0] random_hue();
        logic [HUE_W-1:0] edges[10] = '{9'd0, 9'd42, 9'd43, 9'd214, 9'd215, 9'd258,
                                        9'd359, 9'd360, 9'd361, 9'd511};
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return edges[$urandom_range(0, 9)];
        // above-range hues clamp to 360
        if (r == 1)
            return HUE_W'($urandom_range(361, 511));
        return HUE_W'($urandom_range(0, 360));
    endfunction

    initial
    begin
        logic [HUE_W-1:0] sector_hues[20] = '{9'd0, 9'd42, 9'd43, 9'd85, 9'd86, 9'd128,
                                              9'd129, 9'd171, 9'd172, 9'd214, 9'd215,
                                              9'd257, 9'd258, 9'd300, 9'd301, 9'd343,
                                              9'd344, 9'd360, 9'd361, 9'd511};
        rst_n            = 1'b0;
        pixel.valid      = 1'b0;
        pixel.hue        = '0;
        pixel.saturation = '0;
        pixel.brightness = '0;
        color.ready      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every sector edge at full saturation and brightness
        foreach (sector_hues[i])
            send_pixel(sector_hues[i], FULL_LEVEL, FULL_LEVEL);
        send_pixel(9'd0, 8'd0, 8'd0);
        send_pixel(9'd100, 8'd0, 8'd200);
        send_pixel(9'd200, FULL_LEVEL, 8'd0);
        send_pixel(9'd300, 8'd128, 8'd1);
        send_pixel(9'd511, 8'd1, FULL_LEVEL);

        // hold the sender until the pipe is empty
        @(negedge clk);
        pixel.valid <= 1'b0;
        wait_results_done();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                pixel.valid <= 1'b0;
                wait_results_done();
            end
            send_pixel(random_hue(), random_level(), random_level());
        end

        @(negedge clk);
        pixel.valid <= 1'b0;
        calm = 1'b0;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (check_failures == 0 && results_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/hsvgrb_pkg.sv
hw/rtl/hsv_pixel_if.sv
hw/rtl/grb_word_if.sv
hw/rtl/hsvgrb_sector.sv
hw/rtl/hsvgrb_terms.sv
hw/rtl/hsv_to_grb_color_converter.sv
sim/hsvgrb_checker.sv
sim/tb_hsv_to_grb_color_converter.sv
